// ===== rtl/core/idq_pkg.sv =====
package idq_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int SIZE_W = 7;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_RESIZE     = 3'd4,
        OP_READ       = 3'd5,
        OP_DUMP       = 3'd6,
        OP_WRITE      = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_op                       opcode;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value;
        logic [SIZE_W-1:0]         new_size;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        t_status                   status;
        logic                      last;
    } t_rsp;

endpackage

// ===== rtl/core/idq_ram.sv =====
module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/indexed_double_ended_queue_core.sv =====
// Ring-buffer deque of signed 32-bit values, up to CAPACITY entries. A request
// is taken when start is high and busy is low. Push, pop, resize and write
// finish in the cycle they are taken and never raise busy, so one request per
// cycle is sustained; an out-of-range read and a dump of an empty queue finish
// the same way. An in-range read raises busy for the S_READ state because of
// the registered read of the slot RAM. A dump of a non-empty queue holds busy
// through S_DUMP, one RAM read per entry through the single read port, and the
// S_DRAIN state that drains the last word. Each result
// appears on o_rsp for exactly one cycle with o_strobe, the cycle after its
// request is taken or after its RAM word arrives; the receiver cannot stall,
// and dump results come in consecutive cycles, front first. Slots outside the
// live region read as zero through per-slot valid flops cleared at reset, so
// there is no clearing pass.
module indexed_double_ended_queue_core #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  idq_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output idq_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0] CAP_A = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DUMP  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_head, n_head;
    logic [CW-1:0]               r_count, n_count;
    logic [CAPACITY-1:0]         r_valid, n_valid;
    logic [AW-1:0]               r_idx, n_idx;
    logic                        r_pend, n_pend;
    logic                        r_pend_last, n_pend_last;
    logic                        r_pend_vld, n_pend_vld;
    logic                        r_strobe, n_strobe;
    idq_pkg::t_rsp               r_rsp, n_rsp;

    logic                        we, re;
    logic [AW-1:0]               waddr, raddr;
    logic [idq_pkg::DATA_W-1:0]  wdata, rdata;

    logic                        acc, full, empty, in_range, size_ok;
    logic [CW-1:0]               cnt_m1;
    logic [AW-1:0]               pos_slot;
    logic [CAPACITY-1:0]         drop_mask;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= CAP_A) begin
            s = s - CAP_A;
        end
        return s[AW-1:0];
    endfunction

    assign acc      = start && !busy;
    assign full     = r_count >= CW'(CAPACITY);
    assign empty    = r_count == '0;
    assign in_range = {1'b0, i_req.position} < idq_pkg::SIZE_W'(r_count);
    assign size_ok  = i_req.new_size <= idq_pkg::SIZE_W'(CAPACITY);
    assign cnt_m1   = r_count - CW'(1);
    assign pos_slot = f_phys(r_head, i_req.position[AW-1:0]);

    // mark slots whose logical index falls in [new_size, count)
    always_comb begin
        logic [AW:0] lg;
        logic [AW:0] jj;
        for (int j = 0; j < CAPACITY; j++) begin
            jj = (AW + 1)'(j);
            lg = jj - {1'b0, r_head} + ((jj < {1'b0, r_head}) ? CAP_A : '0);
            drop_mask[j] = (idq_pkg::SIZE_W'(lg) >= i_req.new_size) &&
                           (idq_pkg::SIZE_W'(lg) < idq_pkg::SIZE_W'(r_count));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_valid     = r_valid;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_pend_vld  = r_pend_vld;
        n_strobe    = 1'b0;
        n_rsp       = r_rsp;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        re          = 1'b0;
        raddr       = '0;

        // deliver the RAM word read last cycle
        if (r_pend) begin
            n_strobe      = 1'b1;
            n_rsp.data    = r_pend_vld ? rdata : '0;
            n_rsp.status  = idq_pkg::ST_OK;
            n_rsp.last    = r_pend_last;
        end

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_strobe     = 1'b1;
                    n_rsp.data   = '0;
                    n_rsp.status = idq_pkg::ST_OK;
                    n_rsp.last   = 1'b1;
                    unique case (i_req.opcode)
                        idq_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                n_rsp.status = idq_pkg::ST_FULL;
                            end else begin
                                we             = 1'b1;
                                waddr          = f_phys(r_head, r_count[AW-1:0]);
                                wdata          = i_req.value;
                                n_valid[waddr] = 1'b1;
                                n_count        = r_count + CW'(1);
                            end
                        end
                        idq_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                n_rsp.status = idq_pkg::ST_FULL;
                            end else begin
                                n_head         = (r_head == '0) ? LAST_SLOT
                                                                : r_head - AW'(1);
                                we             = 1'b1;
                                waddr          = n_head;
                                wdata          = i_req.value;
                                n_valid[waddr] = 1'b1;
                                n_count        = r_count + CW'(1);
                            end
                        end
                        idq_pkg::OP_POP_FRONT: begin
                            if (empty) begin
                                n_rsp.status = idq_pkg::ST_EMPTY;
                            end else begin
                                n_valid[r_head] = 1'b0;
                                n_head          = (r_head == LAST_SLOT) ? '0
                                                                        : r_head + AW'(1);
                                n_count         = cnt_m1;
                            end
                        end
                        idq_pkg::OP_POP_BACK: begin
                            if (empty) begin
                                n_rsp.status = idq_pkg::ST_EMPTY;
                            end else begin
                                n_valid[f_phys(r_head, cnt_m1[AW-1:0])] = 1'b0;
                                n_count = cnt_m1;
                            end
                        end
                        idq_pkg::OP_RESIZE: begin
                            if (!size_ok) begin
                                n_rsp.status = idq_pkg::ST_FULL;
                            end else begin
                                n_valid = r_valid & ~drop_mask;
                                n_count = CW'(i_req.new_size);
                            end
                        end
                        idq_pkg::OP_READ: begin
                            if (!in_range) begin
                                n_rsp.status = idq_pkg::ST_RANGE;
                            end else begin
                                n_strobe    = 1'b0;
                                re          = 1'b1;
                                raddr       = pos_slot;
                                n_pend      = 1'b1;
                                n_pend_last = 1'b1;
                                n_pend_vld  = r_valid[pos_slot];
                                n_state     = S_READ;
                            end
                        end
                        idq_pkg::OP_DUMP: begin
                            if (!empty) begin
                                n_strobe = 1'b0;
                                n_idx    = '0;
                                n_state  = S_DUMP;
                            end
                        end
                        idq_pkg::OP_WRITE: begin
                            if (!in_range) begin
                                n_rsp.status = idq_pkg::ST_RANGE;
                            end else begin
                                we                = 1'b1;
                                waddr             = pos_slot;
                                wdata             = i_req.value;
                                n_valid[pos_slot] = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_DUMP: begin
                re          = 1'b1;
                raddr       = f_phys(r_head, r_idx);
                n_pend      = 1'b1;
                n_pend_vld  = r_valid[raddr];
                n_pend_last = (CW'(r_idx) + CW'(1)) == r_count;
                if (n_pend_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_READ, S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_valid  <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_valid  <= n_valid;
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_pend_vld  <= n_pend_vld;
        r_rsp       <= n_rsp;
    end

    idq_ram #(
        .WIDTH (idq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign busy     = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_pend_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state != S_IDLE))
        else $error("RAM read pending while idle");

    a_dump_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.last) |=> o_strobe)
        else $error("gap inside dump burst");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.opcode != idq_pkg::OP_READ) &&
         (i_req.opcode != idq_pkg::OP_DUMP)) |=> (o_strobe && o_rsp.last && !busy))
        else $error("missing single-cycle result");

    a_flag_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_rsp.status != idq_pkg::ST_OK)) |-> (o_rsp.data == '0))
        else $error("flagged result carries data");

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int DEPTH         = 64;
    localparam int NUM_RANDOM    = 160;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int REQ_W         = $bits(idq_pkg::t_req);

    class deque_scoreboard;
        logic signed [idq_pkg::DATA_W-1:0] model_slots [DEPTH];
        logic [idq_pkg::POS_W-1:0]         model_head;
        logic [idq_pkg::SIZE_W-1:0]        model_count;
        idq_pkg::t_rsp                     pending_rsps [$];
        int errors;
        int n_requests;
        int n_results;
        int n_dumps;
        int peak_count;
        int n_status [4];

        function new();
            foreach (model_slots[i]) model_slots[i] = '0;
            model_head  = '0;
            model_count = '0;
            errors      = 0;
            n_requests  = 0;
            n_results   = 0;
            n_dumps     = 0;
            peak_count  = 0;
            foreach (n_status[i]) n_status[i] = 0;
        endfunction

        function logic [idq_pkg::POS_W-1:0] slot_of(int idx);
            return idq_pkg::POS_W'(int'(model_head) + idx);
        endfunction

        function void queue_rsp(logic signed [idq_pkg::DATA_W-1:0] data,
                                idq_pkg::t_status status, logic last);
            idq_pkg::t_rsp r;
            r.data   = data;
            r.status = status;
            r.last   = last;
            pending_rsps = {pending_rsps, r};
        endfunction

        function void note_request(idq_pkg::t_req r);
            idq_pkg::t_status                  st;
            logic signed [idq_pkg::DATA_W-1:0] rd;
            int                                i;
            st = idq_pkg::ST_OK;
            rd = '0;
            n_requests++;
            case (r.opcode)
                idq_pkg::OP_PUSH_BACK: begin
                    if (model_count >= DEPTH) begin
                        st = idq_pkg::ST_FULL;
                    end else begin
                        model_slots[slot_of(model_count)] = r.value;
                        model_count++;
                    end
                end
                idq_pkg::OP_PUSH_FRONT: begin
                    if (model_count >= DEPTH) begin
                        st = idq_pkg::ST_FULL;
                    end else begin
                        model_head = model_head - 1'b1;
                        model_slots[model_head] = r.value;
                        model_count++;
                    end
                end
                idq_pkg::OP_POP_FRONT: begin
                    if (model_count == 0) begin
                        st = idq_pkg::ST_EMPTY;
                    end else begin
                        model_slots[model_head] = '0;
                        model_head = model_head + 1'b1;
                        model_count--;
                    end
                end
                idq_pkg::OP_POP_BACK: begin
                    if (model_count == 0) begin
                        st = idq_pkg::ST_EMPTY;
                    end else begin
                        model_slots[slot_of(model_count - 1)] = '0;
                        model_count--;
                    end
                end
                idq_pkg::OP_RESIZE: begin
                    if (r.new_size > DEPTH) begin
                        st = idq_pkg::ST_FULL;
                    end else begin
                        // clear everything a shrink drops
                        for (i = r.new_size; i < model_count; i++)
                            model_slots[slot_of(i)] = '0;
                        model_count = r.new_size;
                    end
                end
                idq_pkg::OP_READ: begin
                    if (r.position >= model_count) st = idq_pkg::ST_RANGE;
                    else rd = model_slots[slot_of(r.position)];
                end
                idq_pkg::OP_WRITE: begin
                    if (r.position >= model_count) st = idq_pkg::ST_RANGE;
                    else model_slots[slot_of(r.position)] = r.value;
                end
                idq_pkg::OP_DUMP: begin
                    n_dumps++;
                    if (model_count == 0) begin
                        queue_rsp('0, idq_pkg::ST_OK, 1'b1);
                    end else begin
                        for (i = 0; i < model_count; i++)
                            queue_rsp(model_slots[slot_of(i)], idq_pkg::ST_OK,
                                      i == model_count - 1);
                    end
                    return;
                end
                default: ;
            endcase
            if (model_count > peak_count) peak_count = model_count;
            queue_rsp(rd, st, 1'b1);
        endfunction

        function void check_result(idq_pkg::t_rsp got);
            idq_pkg::t_rsp want;
            n_results++;
            if (pending_rsps.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: data %0d status %0d last %0b",
                         $time, got.data, got.status, got.last);
                return;
            end
            want = pending_rsps[0];
            pending_rsps.delete(0);
            n_status[want.status]++;
            if (got.data !== want.data) begin
                errors++;
                $display("%0t: data mismatch: expected %0d, actual %0d",
                         $time, want.data, got.data);
            end
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last mismatch: expected %0b, actual %0b",
                         $time, want.last, got.last);
            end
        endfunction
    endclass

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    idq_pkg::t_req  i_req   = '0;
    logic           busy;
    logic           o_strobe;
    idq_pkg::t_rsp  o_rsp;

    deque_scoreboard sb = new();
    int              idle_cycles = 0;
    bit              burst_mode  = 1'b0;

    indexed_double_ended_queue_core #(.CAPACITY(DEPTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) sb.check_result(o_rsp);
            if (start && busy === 1'b0) sb.note_request(i_req);
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or result accepted for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic idq_pkg::t_req noise_req();
        logic [63:0]      raw;
        logic [REQ_W-1:0] bits;
        raw  = {$urandom, $urandom};
        bits = raw[REQ_W-1:0];
        return idq_pkg::t_req'(bits);
    endfunction

    function automatic idq_pkg::t_req make_req(idq_pkg::t_op op, int pos,
                                               logic signed [idq_pkg::DATA_W-1:0] val,
                                               int nsz);
        idq_pkg::t_req r;
        r          = noise_req();
        r.opcode   = op;
        r.position = idq_pkg::POS_W'(pos);
        r.value    = val;
        r.new_size = idq_pkg::SIZE_W'(nsz);
        return r;
    endfunction

    function automatic idq_pkg::t_req random_item(int live);
        idq_pkg::t_req r;
        int            pick;
        r    = noise_req();
        pick = $urandom_range(0, 99);
        if (pick < 20)      r.opcode = idq_pkg::OP_PUSH_BACK;
        else if (pick < 33) r.opcode = idq_pkg::OP_PUSH_FRONT;
        else if (pick < 43) r.opcode = idq_pkg::OP_POP_FRONT;
        else if (pick < 53) r.opcode = idq_pkg::OP_POP_BACK;
        else if (pick < 61) r.opcode = idq_pkg::OP_RESIZE;
        else if (pick < 76) r.opcode = idq_pkg::OP_READ;
        else if (pick < 82) r.opcode = idq_pkg::OP_DUMP;
        else                r.opcode = idq_pkg::OP_WRITE;
        // mostly hit live entries, sometimes anywhere
        if (live > 0 && $urandom_range(0, 3) != 0)
            r.position = idq_pkg::POS_W'($urandom_range(0, live - 1));
        else
            r.position = idq_pkg::POS_W'($urandom_range(0, 63));
        case ($urandom_range(0, 7))
            0:       r.value = 32'sh7fff_ffff;
            1:       r.value = 32'sh8000_0000;
            2:       r.value = '0;
            3:       r.value = -32'sd1;
            default: r.value = $urandom;
        endcase
        if ($urandom_range(0, 5) == 0)
            r.new_size = idq_pkg::SIZE_W'($urandom_range(65, 127));
        else if ($urandom_range(0, 3) == 0)
            r.new_size = idq_pkg::SIZE_W'($urandom_range(56, 64));
        else
            r.new_size = idq_pkg::SIZE_W'($urandom_range(0, 64));
        return r;
    endfunction

    function automatic int pick_gap();
        int pick;
        if (burst_mode) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // hold the request until taken; lower start only across a real gap
    task automatic send_req(idq_pkg::t_req r, int gap);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            i_req <= noise_req();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        @(posedge i_clk);
        while (sb.pending_rsps.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_req(make_req(idq_pkg::OP_DUMP, 0, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_POP_FRONT, 0, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_POP_BACK, 0, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_READ, 0, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_WRITE, 63, 32'sh1234_5678, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_PUSH_BACK, 0, 32'sh7fff_ffff, 0), pick_gap());
        // head wraps to the top slot
        send_req(make_req(idq_pkg::OP_PUSH_FRONT, 0, 32'sh8000_0000, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_PUSH_BACK, 0, -32'sd1, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_READ, 0, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_READ, 2, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_READ, 3, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_WRITE, 1, 32'sh5a5a_5a5a, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_RESIZE, 0, 0, 65), pick_gap());
        send_req(make_req(idq_pkg::OP_RESIZE, 0, 0, 127), pick_gap());
        send_req(make_req(idq_pkg::OP_RESIZE, 0, 0, 1), pick_gap());
        send_req(make_req(idq_pkg::OP_RESIZE, 0, 0, 5), pick_gap());
        send_req(make_req(idq_pkg::OP_DUMP, 0, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_POP_BACK, 0, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_POP_FRONT, 0, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_RESIZE, 0, 0, 64), pick_gap());
        send_req(make_req(idq_pkg::OP_PUSH_BACK, 0, 32'sh0bad_cafe, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_PUSH_FRONT, 0, 32'sh0bad_cafe, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_WRITE, 63, -32'sd7, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_READ, 63, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_DUMP, 0, 0, 0), pick_gap());
        send_req(make_req(idq_pkg::OP_RESIZE, 0, 0, 0), 1);
        wait_drain();

        for (n = 0; n < NUM_RANDOM; n++) begin
            if (n % 20 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (n % 50 == 49) begin
                send_req(random_item(sb.model_count), $urandom_range(1, 4));
                wait_drain();
            end else begin
                send_req(random_item(sb.model_count), pick_gap());
            end
        end
        start <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests with %0d dumps and %0d results; peak depth %0d.",
                 sb.n_requests, sb.n_dumps, sb.n_results, sb.peak_count);
        $display("Flagged results: %0d full or oversize, %0d empty, %0d out of range.",
                 sb.n_status[idq_pkg::ST_FULL], sb.n_status[idq_pkg::ST_EMPTY],
                 sb.n_status[idq_pkg::ST_RANGE]);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
